// ===== rtl/tli_pkg.sv =====
// ============================================================================
// tli_pkg: shared types and constants of the trilinear interpolator
// Field widths, register indexes and the fixed pipeline latency.
// ============================================================================
`default_nettype none

package tli_pkg;

   localparam int DATA_W        = 32;  // points, offsets, corner values, result
   localparam int SPACE_W       = 31;  // unsigned grid spacing
   localparam int POS_W         = 33;  // magnitude of an offset-corrected position
   localparam int CSR_IDX_W     = 3;
   localparam int FRAC_BITS_DEF = 16;

   // Per interpolation pass: difference, multiply, magnitude, one divider
   // stage per quotient bit, and the final correction.
   localparam int LERP_LAT = 4 + DATA_W;
   // Input register, cell position divider, its correction, three passes
   // and the output register.
   localparam int LATENCY  = 1 + POS_W + 1 + 3 * LERP_LAT + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPACING_X = 3'd0,
      CSR_SPACING_Y = 3'd1,
      CSR_SPACING_Z = 3'd2,
      CSR_OFFSET_X  = 3'd3,
      CSR_OFFSET_Y  = 3'd4,
      CSR_OFFSET_Z  = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/tli_div_pipe.sv =====
// ============================================================================
// tli_div_pipe: pipelined restoring divider
// One quotient bit per register stage, several lanes in lockstep, each
// lane with its own divisor, plus a side word that travels along.
// ============================================================================
`default_nettype none

module tli_div_pipe #(
   parameter int LANES  = 1,
   parameter int DEN_W  = 31,
   parameter int Q_W    = 32,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [DEN_W-1:0]  den      [LANES],
   input  wire logic [DEN_W-1:0]  hi       [LANES],
   input  wire logic [Q_W-1:0]    lo       [LANES],
   input  wire logic [SIDE_W-1:0] side_in,
   output logic                   out_valid,
   output logic [Q_W-1:0]         quot_out [LANES],
   output logic [DEN_W-1:0]       rem_out  [LANES],
   output logic [SIDE_W-1:0]      side_out
);

   // The high part must be below the divisor; the shift word takes in the
   // dividend bits at its top and the quotient bits at its bottom.
   logic [Q_W-1:0]    valid_ff;
   logic [DEN_W-1:0]  rem_ff  [Q_W][LANES];
   logic [DEN_W-1:0]  rem_in  [Q_W][LANES];
   logic [Q_W-1:0]    word_ff [Q_W][LANES];
   logic [Q_W-1:0]    word_in [Q_W][LANES];
   logic [SIDE_W-1:0] side_ff [Q_W];

   always_comb begin
      logic [DEN_W-1:0] rem_prev;
      logic [Q_W-1:0]   word_prev;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      for (int k = 0; k < Q_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            rem_prev  = (k == 0) ? hi[l] : rem_ff[k-1][l];
            word_prev = (k == 0) ? lo[l] : word_ff[k-1][l];
            trial     = {rem_prev, word_prev[Q_W-1]};
            diff      = trial - {1'b0, den[l]};
            // The trial stays below twice the divisor, so the top bit is the borrow.
            rem_in[k][l]  = diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
            word_in[k][l] = {word_prev[Q_W-2:0], ~diff[DEN_W]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[Q_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      word_ff    <= word_in;
      side_ff[0] <= side_in;
      for (int k = 1; k < Q_W; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign quot_out  = word_ff[Q_W-1];
   assign rem_out   = rem_ff[Q_W-1];
   assign side_out  = side_ff[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/tli_lerp.sv =====
// ============================================================================
// tli_lerp: one pass of linear interpolation over several lanes
// Computes f0 + floor(r * (f1 - f0) / spacing) per lane, pipelined.
// ============================================================================
`default_nettype none

module tli_lerp
   import tli_pkg::*;
#(
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [SPACE_W-1:0]       spacing,
   input  wire logic [SPACE_W-1:0]       r,
   input  wire logic signed [DATA_W-1:0] f0 [LANES],
   input  wire logic signed [DATA_W-1:0] f1 [LANES],
   input  wire logic [SIDE_W-1:0]        side_in,
   output logic                          out_valid,
   output logic signed [DATA_W-1:0]      res [LANES],
   output logic [SIDE_W-1:0]             side_out
);

   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = 2 * DATA_W;
   localparam int MAG_W  = PROD_W - 1;
   localparam int LW     = 1 + DATA_W;
   localparam int DSIDE  = SIDE_W + LANES * LW;

   // Difference stage.
   logic                     v0_ff;
   logic [SPACE_W-1:0]       r0_ff;
   logic signed [DATA_W-1:0] base0_ff [LANES];
   logic signed [DIFF_W-1:0] diff0_ff [LANES];
   logic [SIDE_W-1:0]        side0_ff;
   // Multiply stage.
   logic                     v1_ff;
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [PROD_W-1:0] prod_in [LANES];
   logic signed [DATA_W-1:0] base1_ff [LANES];
   logic [SIDE_W-1:0]        side1_ff;
   // Magnitude stage.
   logic                     v2_ff;
   logic [MAG_W-1:0]         mag_ff [LANES];
   logic                     neg_ff [LANES];
   logic signed [DATA_W-1:0] base2_ff [LANES];
   logic [SIDE_W-1:0]        side2_ff;
   // Divider.
   logic [SPACE_W-1:0]       d_den [LANES];
   logic [SPACE_W-1:0]       d_hi  [LANES];
   logic [DATA_W-1:0]        d_lo  [LANES];
   logic [DSIDE-1:0]         d_side_in;
   logic                     d_valid;
   logic [DATA_W-1:0]        d_quot [LANES];
   logic [SPACE_W-1:0]       d_rem  [LANES];
   logic [DSIDE-1:0]         d_side_out;
   // Correction stage.
   logic                     v3_ff;
   logic signed [DATA_W-1:0] res_ff [LANES];
   logic signed [DATA_W-1:0] res_in [LANES];
   logic [SIDE_W-1:0]        side3_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         prod_in[l] = $signed({1'b0, r0_ff}) * diff0_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff    <= r;
      side0_ff <= side_in;
      side1_ff <= side0_ff;
      side2_ff <= side1_ff;
      side3_ff <= d_side_out[DSIDE-1 -: SIDE_W];
      for (int l = 0; l < LANES; l++) begin
         base0_ff[l] <= f0[l];
         diff0_ff[l] <= DIFF_W'(f1[l]) - DIFF_W'(f0[l]);
         prod_ff[l]  <= prod_in[l];
         base1_ff[l] <= base0_ff[l];
         neg_ff[l]   <= prod_ff[l][PROD_W-1];
         mag_ff[l]   <= prod_ff[l][PROD_W-1] ? MAG_W'(-prod_ff[l]) : MAG_W'(prod_ff[l]);
         base2_ff[l] <= base1_ff[l];
      end
      res_ff <= res_in;
   end

   always_comb begin
      d_side_in[DSIDE-1 -: SIDE_W] = side2_ff;
      for (int l = 0; l < LANES; l++) begin
         d_den[l] = spacing;
         d_hi[l]  = mag_ff[l][MAG_W-1:DATA_W];
         d_lo[l]  = mag_ff[l][DATA_W-1:0];
         d_side_in[l*LW +: LW] = {neg_ff[l], base2_ff[l]};
      end
   end

   tli_div_pipe #(
      .LANES  (LANES),
      .DEN_W  (SPACE_W),
      .Q_W    (DATA_W),
      .SIDE_W (DSIDE)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .den       (d_den),
      .hi        (d_hi),
      .lo        (d_lo),
      .side_in   (d_side_in),
      .out_valid (d_valid),
      .quot_out  (d_quot),
      .rem_out   (d_rem),
      .side_out  (d_side_out)
   );

   // A negative product rounds away from zero when the division is inexact.
   always_comb begin
      logic [DATA_W+1:0]        adj;
      logic signed [DATA_W+1:0] step;
      logic signed [DATA_W+1:0] sum;
      logic                     neg;
      logic signed [DATA_W-1:0] base;
      for (int l = 0; l < LANES; l++) begin
         {neg, base} = d_side_out[l*LW +: LW];
         adj  = {2'b00, d_quot[l]} + (DATA_W+2)'(neg && d_rem[l] != '0);
         step = neg ? -$signed(adj) : $signed(adj);
         sum  = (DATA_W+2)'(base) + step;
         res_in[l] = sum[DATA_W-1:0];
      end
   end

   assign out_valid = v3_ff;
   assign res       = res_ff;
   assign side_out  = side3_ff;

endmodule

`default_nettype wire

// ===== rtl/trilinear_interpolator_core.sv =====
// ============================================================================
// trilinear_interpolator_core: streaming trilinear interpolation
// Finds the in-cell position of a point on an offset grid and blends the
// eight corner values along x, y and z, all in signed fixed point.
// ============================================================================
//
//   channel   ports                          direction   handshake
//   request   start, busy, req_*             in          start && !busy
//   response  rsp_strobe, rsp_*              out         strobe, one cycle
//   config    csr_valid, csr_ready, csr_*    in          csr_valid && csr_ready
//
// A new word is accepted on every cycle; busy is always low. Results come
// out in the order of their requests. Most of the pipeline depth lies in
// the bit-serial pipelined dividers: 33 stages for the cell position and
// 32 for each of the three interpolation passes. Reset is synchronous,
// clears all valid bits and sets the configuration registers to their
// reset values. The receiver cannot stall, so nothing ever holds.
// ============================================================================
`default_nettype none

module trilinear_interpolator_core
   import tli_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [DATA_W-1:0] req_point_x,
   input  wire logic signed [DATA_W-1:0] req_point_y,
   input  wire logic signed [DATA_W-1:0] req_point_z,
   input  wire logic signed [DATA_W-1:0] req_corner_000,
   input  wire logic signed [DATA_W-1:0] req_corner_100,
   input  wire logic signed [DATA_W-1:0] req_corner_001,
   input  wire logic signed [DATA_W-1:0] req_corner_101,
   input  wire logic signed [DATA_W-1:0] req_corner_010,
   input  wire logic signed [DATA_W-1:0] req_corner_110,
   input  wire logic signed [DATA_W-1:0] req_corner_011,
   input  wire logic signed [DATA_W-1:0] req_corner_111,
   output logic                          rsp_strobe,
   output logic signed [DATA_W-1:0]      rsp_interpolated_value,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [DATA_W-1:0]        csr_data
);

   localparam int NC    = 8;
   localparam int CSIDE = 3 + NC * DATA_W;

   // Configuration registers, read directly by every stage. The user must
   // change them only while no word is in flight; nothing enforces it.
   logic [SPACE_W-1:0] spacing_x_ff, spacing_y_ff, spacing_z_ff;
   logic [DATA_W-1:0]  offset_x_ff, offset_y_ff, offset_z_ff;
   logic [SPACE_W-1:0] sx, sy, sz;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_x_ff <= SPACE_W'(1) << FRAC_BITS;
         spacing_y_ff <= SPACE_W'(1) << FRAC_BITS;
         spacing_z_ff <= SPACE_W'(1) << FRAC_BITS;
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         offset_z_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPACING_X: spacing_x_ff <= csr_data[SPACE_W-1:0];
            CSR_SPACING_Y: spacing_y_ff <= csr_data[SPACE_W-1:0];
            CSR_SPACING_Z: spacing_z_ff <= csr_data[SPACE_W-1:0];
            CSR_OFFSET_X:  offset_x_ff  <= csr_data;
            CSR_OFFSET_Y:  offset_y_ff  <= csr_data;
            CSR_OFFSET_Z:  offset_z_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // A spacing of zero behaves as one LSB.
   assign sx = (spacing_x_ff == '0) ? SPACE_W'(1) : spacing_x_ff;
   assign sy = (spacing_y_ff == '0) ? SPACE_W'(1) : spacing_y_ff;
   assign sz = (spacing_z_ff == '0) ? SPACE_W'(1) : spacing_z_ff;

   // Input register.
   logic                     in_v_ff;
   logic signed [DATA_W-1:0] pt_ff [3];
   logic signed [DATA_W-1:0] cor_ff [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff[0]  <= req_point_x;
      pt_ff[1]  <= req_point_y;
      pt_ff[2]  <= req_point_z;
      cor_ff[0] <= req_corner_000;
      cor_ff[1] <= req_corner_100;
      cor_ff[2] <= req_corner_001;
      cor_ff[3] <= req_corner_101;
      cor_ff[4] <= req_corner_010;
      cor_ff[5] <= req_corner_110;
      cor_ff[6] <= req_corner_011;
      cor_ff[7] <= req_corner_111;
   end

   // Cell position: |p - offset| mod spacing for each axis, sign carried along.
   logic [SPACE_W-1:0] pd_den [3];
   logic [SPACE_W-1:0] pd_hi  [3];
   logic [POS_W-1:0]   pd_lo  [3];
   logic [CSIDE-1:0]   pd_side_in, pd_side_out;
   logic               pd_valid;
   logic [SPACE_W-1:0] pd_rem [3];
   logic [DATA_W-1:0]  off [3];

   assign off[0]    = offset_x_ff;
   assign off[1]    = offset_y_ff;
   assign off[2]    = offset_z_ff;
   assign pd_den[0] = sx;
   assign pd_den[1] = sy;
   assign pd_den[2] = sz;

   always_comb begin
      logic signed [POS_W-1:0] d;
      for (int a = 0; a < 3; a++) begin
         d = POS_W'(pt_ff[a]) - POS_W'($signed(off[a]));
         pd_hi[a] = '0;
         pd_lo[a] = d[POS_W-1] ? POS_W'(-d) : POS_W'(d);
         pd_side_in[NC*DATA_W + a] = d[POS_W-1];
      end
      for (int c = 0; c < NC; c++) begin
         pd_side_in[c*DATA_W +: DATA_W] = cor_ff[c];
      end
   end

   tli_div_pipe #(
      .LANES  (3),
      .DEN_W  (SPACE_W),
      .Q_W    (POS_W),
      .SIDE_W (CSIDE)
   ) u_pos_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .den       (pd_den),
      .hi        (pd_hi),
      .lo        (pd_lo),
      .side_in   (pd_side_in),
      .out_valid (pd_valid),
      .quot_out  (),
      .rem_out   (pd_rem),
      .side_out  (pd_side_out)
   );

   // A negative distance with a nonzero remainder folds back into the cell.
   logic                     pos_v_ff;
   logic [SPACE_W-1:0]       r_ff [3];
   logic signed [DATA_W-1:0] pc_ff [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_v_ff <= 1'b0;
      end else begin
         pos_v_ff <= pd_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         r_ff[a] <= (pd_side_out[NC*DATA_W + a] && pd_rem[a] != '0)
                    ? pd_den[a] - pd_rem[a] : pd_rem[a];
      end
      for (int c = 0; c < NC; c++) begin
         pc_ff[c] <= pd_side_out[c*DATA_W +: DATA_W];
      end
   end

   // Four blends along x: lanes are the (y,z) pairs 00, 01, 10, 11.
   logic signed [DATA_W-1:0] x_f0 [4];
   logic signed [DATA_W-1:0] x_f1 [4];
   logic signed [DATA_W-1:0] x_res [4];
   logic [2*SPACE_W-1:0]     x_side;
   logic                     x_valid;

   assign x_f0[0] = pc_ff[0];
   assign x_f1[0] = pc_ff[1];
   assign x_f0[1] = pc_ff[2];
   assign x_f1[1] = pc_ff[3];
   assign x_f0[2] = pc_ff[4];
   assign x_f1[2] = pc_ff[5];
   assign x_f0[3] = pc_ff[6];
   assign x_f1[3] = pc_ff[7];

   tli_lerp #(
      .LANES  (4),
      .SIDE_W (2 * SPACE_W)
   ) u_lerp_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pos_v_ff),
      .spacing   (sx),
      .r         (r_ff[0]),
      .f0        (x_f0),
      .f1        (x_f1),
      .side_in   ({r_ff[1], r_ff[2]}),
      .out_valid (x_valid),
      .res       (x_res),
      .side_out  (x_side)
   );

   // Two blends along y: lanes are z low and z high.
   logic signed [DATA_W-1:0] y_f0 [2];
   logic signed [DATA_W-1:0] y_f1 [2];
   logic signed [DATA_W-1:0] y_res [2];
   logic [SPACE_W-1:0]       y_side;
   logic                     y_valid;

   assign y_f0[0] = x_res[0];
   assign y_f1[0] = x_res[2];
   assign y_f0[1] = x_res[1];
   assign y_f1[1] = x_res[3];

   tli_lerp #(
      .LANES  (2),
      .SIDE_W (SPACE_W)
   ) u_lerp_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x_valid),
      .spacing   (sy),
      .r         (x_side[2*SPACE_W-1:SPACE_W]),
      .f0        (y_f0),
      .f1        (y_f1),
      .side_in   (x_side[SPACE_W-1:0]),
      .out_valid (y_valid),
      .res       (y_res),
      .side_out  (y_side)
   );

   // Final blend along z.
   logic signed [DATA_W-1:0] z_f0 [1];
   logic signed [DATA_W-1:0] z_f1 [1];
   logic signed [DATA_W-1:0] z_res [1];
   logic                     z_valid;

   assign z_f0[0] = y_res[0];
   assign z_f1[0] = y_res[1];

   tli_lerp #(
      .LANES  (1),
      .SIDE_W (1)
   ) u_lerp_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (y_valid),
      .spacing   (sz),
      .r         (y_side),
      .f0        (z_f0),
      .f1        (z_f1),
      .side_in   (1'b0),
      .out_valid (z_valid),
      .res       (z_res),
      .side_out  ()
   );

   // Output register. Every blend is a convex combination, so the value
   // already lies in the signed range and needs no clamping.
   logic                     strobe_ff;
   logic signed [DATA_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= z_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= z_res[0];
   end

   assign rsp_strobe             = strobe_ff;
   assign rsp_interpolated_value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/tli_checker.sv =====
// ============================================================================
// tli_checker: port-level checks of the trilinear interpolator
// Watches the top level's ports only; attached by the bind below.
// ============================================================================
`default_nettype none

module tli_checker
   import tli_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic                     csr_valid,
   input wire logic                     csr_ready,
   input wire logic                     rsp_strobe,
   input wire logic signed [DATA_W-1:0] rsp_interpolated_value,
   input wire logic signed [DATA_W-1:0] req_corner_000,
   input wire logic signed [DATA_W-1:0] req_corner_100,
   input wire logic signed [DATA_W-1:0] req_corner_001,
   input wire logic signed [DATA_W-1:0] req_corner_101,
   input wire logic signed [DATA_W-1:0] req_corner_010,
   input wire logic signed [DATA_W-1:0] req_corner_110,
   input wire logic signed [DATA_W-1:0] req_corner_011,
   input wire logic signed [DATA_W-1:0] req_corner_111
);

   logic flat;

   assign flat = req_corner_000 == req_corner_100 && req_corner_000 == req_corner_001 &&
                 req_corner_000 == req_corner_101 && req_corner_000 == req_corner_010 &&
                 req_corner_000 == req_corner_110 && req_corner_000 == req_corner_011 &&
                 req_corner_000 == req_corner_111;

   // A result only ever follows a request by the fixed pipeline latency.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching request");

   // A flat cell must give back its common corner value unchanged.
   a_flat_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(flat, LATENCY))
      |-> rsp_interpolated_value == $past(req_corner_000, LATENCY))
      else $error("flat cell changed its value");

   // The streaming core never holds off requests or configuration writes.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy && (!csr_valid || csr_ready))
      else $error("request or configuration refused");

endmodule

bind trilinear_interpolator_core tli_checker u_tli_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// ============================================================================
// tb: testbench of trilinear_interpolator_core
// Streams points and corner values through the interpolator, predicts each
// blended value in fixed point and compares it with the strobed result.
// ============================================================================
`timescale 1ns / 1ps

module tb;
   import tli_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [DATA_W-1:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic signed [DATA_W-1:0] req_corner_000 = '0, req_corner_100 = '0;
   logic signed [DATA_W-1:0] req_corner_001 = '0, req_corner_101 = '0;
   logic signed [DATA_W-1:0] req_corner_010 = '0, req_corner_110 = '0;
   logic signed [DATA_W-1:0] req_corner_011 = '0, req_corner_111 = '0;
   logic rsp_strobe;
   logic signed [DATA_W-1:0] rsp_interpolated_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   trilinear_interpolator_core DUT (.*);

   always #4 clock = ~clock;

   // The predictor keeps its own copy of the grid registers.
   logic [SPACE_W-1:0] grid_spacing [3];
   logic [DATA_W-1:0]  grid_offset [3];
   logic signed [DATA_W-1:0] expected_values [$];
   int mismatch_count = 0;
   int idle_cycles = 0;

   function automatic longint signed floor_quotient(longint signed num, longint signed s);
      longint signed q;
      q = num / s;
      if ((num % s) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint signed blend(longint signed lo, longint signed hi,
                                           longint signed r, longint signed s);
      return floor_quotient((s - r) * lo + r * hi, s);
   endfunction

   function automatic longint signed active_spacing(int axis);
      return (grid_spacing[axis] == 0) ? 64'sd1 : longint'(grid_spacing[axis]);
   endfunction

   function automatic longint signed in_cell(int axis, logic signed [DATA_W-1:0] p);
      longint signed d, r, s;
      s = active_spacing(axis);
      d = longint'(p) - longint'($signed(grid_offset[axis]));
      r = d % s;
      if (r < 0) r = r + s;
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] interpolate(
         logic signed [DATA_W-1:0] px, py, pz, c000, c100, c001, c101,
         c010, c110, c011, c111);
      longint signed sx, sy, sz, rx, ry, rz, a00, a01, a10, a11, b0, b1, v;
      sx = active_spacing(0); sy = active_spacing(1); sz = active_spacing(2);
      rx = in_cell(0, px); ry = in_cell(1, py); rz = in_cell(2, pz);
      a00 = blend(c000, c100, rx, sx);
      a01 = blend(c001, c101, rx, sx);
      a10 = blend(c010, c110, rx, sx);
      a11 = blend(c011, c111, rx, sx);
      b0 = blend(a00, a10, ry, sy);
      b1 = blend(a01, a11, ry, sy);
      v = blend(b0, b1, rz, sz);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[DATA_W-1:0];
   endfunction

   // Result checker: every strobed word must match the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_values.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result word %0d", rsp_interpolated_value);
         end else begin
            if (rsp_interpolated_value !== expected_values[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected %0d actual %0d",
                           expected_values[0], rsp_interpolated_value);
            end
            void'(expected_values.pop_front());
         end
      end
   end

   // Watchdog: counts cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_register(csr_index_type idx, logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= CSR_SPACING_Z) grid_spacing[idx] = value[SPACE_W-1:0];
      else grid_offset[idx - CSR_OFFSET_X] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits for all results, then the pipeline depth, before touching registers.
   task automatic drain;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Sends one word; start stays high across back-to-back items.
   task automatic send_point(logic signed [DATA_W-1:0] v [11], bit keep_start);
      @(negedge clock);
      start <= 1'b1;
      req_point_x <= v[0]; req_point_y <= v[1]; req_point_z <= v[2];
      req_corner_000 <= v[3]; req_corner_100 <= v[4];
      req_corner_001 <= v[5]; req_corner_101 <= v[6];
      req_corner_010 <= v[7]; req_corner_110 <= v[8];
      req_corner_011 <= v[9]; req_corner_111 <= v[10];
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_values.push_back(interpolate(v[0], v[1], v[2], v[3], v[4],
                                            v[5], v[6], v[7], v[8], v[9], v[10]));
      if (!keep_start) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   function automatic logic [DATA_W-1:0] random_extreme();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed;
      logic signed [DATA_W-1:0] v [11];
      for (int k = 0; k < 12; k++) begin
         for (int f = 0; f < 11; f++) v[f] = (k < 4) ? random_extreme() : $urandom;
         if (k == 0) foreach (v[f]) v[f] = 32'h7FFF_FFFF;
         if (k == 1) foreach (v[f]) v[f] = 32'h8000_0000;
         if (k == 2) begin
            // Points exactly on a grid node and corners at opposite extremes.
            v[0] = 32'h0003_0000; v[1] = -32'sh0002_0000; v[2] = 0;
            for (int f = 3; f < 11; f++) v[f] = f[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
         end
         send_point(v, 1'b0);
      end
   endtask

   task automatic test_spacing_extremes;
      logic signed [DATA_W-1:0] v [11];
      // A zero spacing behaves as one LSB; the widest spacing too, and
      // wide data checks masking to the spacing width.
      write_register(CSR_SPACING_X, 32'h0);
      write_register(CSR_SPACING_Y, 32'hFFFF_FFFF);
      write_register(CSR_SPACING_Z, 32'h7FFF_FFFF);
      write_register(CSR_OFFSET_X, 32'h8000_0000);
      write_register(CSR_OFFSET_Y, 32'h7FFF_FFFF);
      write_register(CSR_OFFSET_Z, 32'hFFFF_0000);
      for (int k = 0; k < 12; k++) begin
         for (int f = 0; f < 11; f++) v[f] = random_extreme();
         send_point(v, 1'b0);
      end
      drain();
   endtask

   task automatic test_random_phase(int count, bit small_grid);
      logic signed [DATA_W-1:0] v [11];
      int burst;
      for (int a = 0; a < 3; a++) begin
         write_register(csr_index_type'(a), small_grid ? $urandom_range(0, 32'h0004_0000)
                                                       : $urandom);
         write_register(csr_index_type'(CSR_OFFSET_X + a), $urandom);
      end
      // A write to an unused index must leave the grid alone.
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= 3'd7; csr_data <= $urandom;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && count > 0; b++) begin
            for (int f = 0; f < 11; f++) v[f] = ($urandom_range(0, 9) == 0)
                                                ? random_extreme() : $urandom;
            count--;
            send_point(v, (b < burst - 1) && (count > 0));
         end
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      drain();
   endtask

   initial begin
      grid_spacing[0] = 31'h1_0000; grid_spacing[1] = 31'h1_0000;
      grid_spacing[2] = 31'h1_0000;
      grid_offset[0] = '0; grid_offset[1] = '0; grid_offset[2] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain();
      test_spacing_extremes();
      for (int phase = 0; phase < 6; phase++) test_random_phase(270, phase[0]);
      drain();
      if (mismatch_count == 0 && expected_values.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
